### hdl/ngd_pkg.sv
// Package for the NAND geometry decoder: stage types, fixed constants,
// device ID capacity table and bad-block marker position table.
// Depends on nothing.
package ngd_pkg;

  localparam int unsigned SECTOR_BYTES   = 512;
  localparam int unsigned CW_PLAIN       = 528;
  localparam int unsigned CW_BCH8        = 532;
  localparam logic [20:0] UNKNOWN_BLOCKS = 21'h800;
  localparam logic [31:0] SPECIAL_ID_A   = 32'h2690ac2c;
  localparam logic [31:0] SPECIAL_ID_B   = 32'h2690ac98;
  localparam logic [9:0]  SPECIAL_OOB    = 10'd256;

  // First stage: raw fields pulled out of the request
  typedef struct packed {
    logic [16:0] chip_mb;
    logic        special_id;
    logic [1:0]  page_sel;
    logic        oob_sel;
    logic [1:0]  blk_sel;
    logic        bch;
    logic [1:0]  bch_code;
    logic [4:0]  esize;
    logic [9:0]  mark_pos;
    logic        mark_spare;
    logic        wide;
  } s1_t;

  // Second stage: derived geometry, final selects still pending
  typedef struct packed {
    logic [16:0] chip_mb;
    logic        special_id;
    logic [13:0] page;
    logic [9:0]  blk;
    logic [4:0]  spp;
    logic        bch;
    logic [4:0]  esize;
    logic [4:0]  ebits;
    logic [9:0]  mark_pos;
    logic        mark_spare;
    logic [9:0]  mark_calc;
    logic [20:0] blocks;
    logic [9:0]  oob_calc;
    logic        wide;
  } s2_t;

  // Result as it leaves the block
  typedef struct packed {
    logic [16:0] chip_size_mb;
    logic [13:0] page_size_bytes;
    logic [9:0]  block_size_kb;
    logic [4:0]  sectors_per_page;
    logic        bch_selected;
    logic [4:0]  ecc_size_bytes;
    logic [4:0]  ecc_correct_bits;
    logic [9:0]  bad_mark_position;
    logic        bad_mark_in_spare;
    logic [20:0] total_blocks;
    logic [9:0]  oob_size_bytes;
    logic        wide_bus;
  } res_t;

  // Device ID byte to capacity in MiB; zero for an unknown device
  function automatic logic [16:0] chip_mb_lookup(input logic [7:0] dev);
    logic [16:0] mb;
    unique case (dev)
      8'h33, 8'h73, 8'h43, 8'h53: mb = 17'd16;
      8'h35, 8'h75, 8'h45, 8'h55: mb = 17'd32;
      8'h36, 8'h76, 8'h46, 8'h56: mb = 17'd64;
      8'h78, 8'h39, 8'h79, 8'h72, 8'h49, 8'h74, 8'h59: mb = 17'd128;
      8'h71: mb = 17'd256;
      8'hA2, 8'hA0, 8'hF2, 8'hD0, 8'hB2, 8'hB0, 8'hC2, 8'hC0: mb = 17'd64;
      8'hA1, 8'hF1, 8'hD1, 8'hB1, 8'hC1, 8'hAD: mb = 17'd128;
      8'hAA, 8'hDA, 8'hBA, 8'hCA: mb = 17'd256;
      8'hAC, 8'hDC, 8'hBC, 8'hCC: mb = 17'd512;
      8'hA3, 8'hD3, 8'hB3, 8'hC3: mb = 17'd1024;
      8'hA5, 8'hD5, 8'hB5, 8'hC5: mb = 17'd2048;
      8'hA7, 8'hD7, 8'hB7, 8'hC7: mb = 17'd4096;
      8'hAE, 8'hDE, 8'hBE, 8'hCE: mb = 17'd8192;
      8'h1A, 8'h3A, 8'h2A, 8'h4A: mb = 17'd16384;
      8'h1C, 8'h3C, 8'h2C, 8'h4C: mb = 17'd32768;
      8'h1E, 8'h3E, 8'h2E, 8'h4E: mb = 17'd65536;
      default: mb = 17'd0;
    endcase
    return mb;
  endfunction

  // Marker in the user area: page - cw * (sectors - 1) + 1
  function automatic logic [9:0] mark_calc_lookup(input logic [1:0] page_sel,
                                                  input logic       bch8);
    logic [9:0] pos;
    unique case ({page_sel, bch8})
      3'b000: pos = 10'(1024 - CW_PLAIN * 1 + 1);
      3'b001: pos = 10'(1024 - CW_BCH8 * 1 + 1);
      3'b010: pos = 10'(2048 - CW_PLAIN * 3 + 1);
      3'b011: pos = 10'(2048 - CW_BCH8 * 3 + 1);
      3'b100: pos = 10'(4096 - CW_PLAIN * 7 + 1);
      3'b101: pos = 10'(4096 - CW_BCH8 * 7 + 1);
      3'b110: pos = 10'(8192 - CW_PLAIN * 15 + 1);
      3'b111: pos = 10'(8192 - CW_BCH8 * 15 + 1);
      default: pos = 10'(1024 - CW_PLAIN * 1 + 1);
    endcase
    return pos;
  endfunction

endpackage

### hdl/nand_geometry_decode.sv
// NAND geometry decoder: turns a read-ID word and controller words into
// flash geometry. A request is registered in stage 1, then stage 2, then the
// output register, whose valid bit drives out_valid_o.
// Throughput one request per cycle unless out_ready_i stalls; three register
// stages, each with its own valid bit, stall from the output back; empty ones move.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears the OOB override.
module nand_geometry_decode
  import ngd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] id_word_i,
  input  logic [31:0] cfg0_word_i,
  input  logic [31:0] cfg1_word_i,
  input  logic [31:0] ecc_cfg_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] chip_size_mb_o,
  output logic [13:0] page_size_bytes_o,
  output logic [9:0]  block_size_kb_o,
  output logic [4:0]  sectors_per_page_o,
  output logic        bch_selected_o,
  output logic [4:0]  ecc_size_bytes_o,
  output logic [4:0]  ecc_correct_bits_o,
  output logic [9:0]  bad_mark_position_o,
  output logic        bad_mark_in_spare_o,
  output logic [20:0] total_blocks_o,
  output logic [9:0]  oob_size_bytes_o,
  output logic        wide_bus_o
);

  logic [9:0] oob_override_q;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  res_t res_d, res_q;

  // Override register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oob_override_q <= '0;
    end else if (cfg_we_i) begin
      oob_override_q <= cfg_wdata_i;
    end
  end

  // Stall chain: a stage moves when it is empty or the next one moves
  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Stage 1: field extraction and device table lookup
  always_comb begin
    s1_d.chip_mb    = chip_mb_lookup(id_word_i[15:8]);
    s1_d.special_id = (id_word_i == SPECIAL_ID_A) || (id_word_i == SPECIAL_ID_B);
    s1_d.page_sel   = id_word_i[25:24];
    s1_d.oob_sel    = id_word_i[26];
    s1_d.blk_sel    = id_word_i[29:28];
    s1_d.bch        = cfg1_word_i[27];
    s1_d.bch_code   = ecc_cfg_word_i[5:4];
    s1_d.esize      = cfg1_word_i[27] ? ecc_cfg_word_i[12:8]
                                      : {1'b0, cfg0_word_i[22:19]};
    s1_d.mark_pos   = cfg1_word_i[15:6];
    s1_d.mark_spare = cfg1_word_i[16];
    s1_d.wide       = cfg1_word_i[1];
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv1) s1_q <= s1_d;
  end

  // Stage 2: sizes, correction strength, computed marker, block count, OOB size
  always_comb begin
    logic bch8;
    bch8           = s1_q.bch && (s1_q.bch_code == 2'd1);
    s2_d.chip_mb   = s1_q.chip_mb;
    s2_d.special_id = s1_q.special_id;
    s2_d.page      = 14'd1024 << s1_q.page_sel;
    s2_d.blk       = 10'd64 << s1_q.blk_sel;
    s2_d.spp       = 5'd2 << s1_q.page_sel;
    s2_d.bch       = s1_q.bch;
    s2_d.esize     = s1_q.esize;
    if (s1_q.bch && (s1_q.bch_code != 2'd0)) begin
      s2_d.ebits = 5'({3'b000, s1_q.bch_code} + 5'd1) << 2;
    end else begin
      s2_d.ebits = 5'd4;
    end
    s2_d.mark_pos   = s1_q.mark_pos;
    s2_d.mark_spare = s1_q.mark_spare;
    s2_d.mark_calc  = mark_calc_lookup(s1_q.page_sel, bch8);
    // capacity and block size are powers of two: blocks = mb * 16 >> blk_sel
    s2_d.blocks     = (s1_q.chip_mb == '0) ? UNKNOWN_BLOCKS
                                           : ({s1_q.chip_mb, 4'b0000} >> s1_q.blk_sel);
    s2_d.oob_calc   = 10'd16 << ({1'b0, s1_q.page_sel} + {2'b00, s1_q.oob_sel});
    s2_d.wide       = s1_q.wide;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && adv2) s2_q <= s2_d;
  end

  // Stage 3: marker and OOB selection into the output register
  always_comb begin
    res_d.chip_size_mb     = s2_q.chip_mb;
    res_d.page_size_bytes  = s2_q.page;
    res_d.block_size_kb    = s2_q.blk;
    res_d.sectors_per_page = s2_q.spp;
    res_d.bch_selected     = s2_q.bch;
    res_d.ecc_size_bytes   = s2_q.esize;
    res_d.ecc_correct_bits = s2_q.ebits;
    if (s2_q.mark_pos == '0) begin
      res_d.bad_mark_position = s2_q.mark_calc;
      res_d.bad_mark_in_spare = 1'b0;
    end else begin
      res_d.bad_mark_position = s2_q.mark_pos;
      res_d.bad_mark_in_spare = s2_q.mark_spare;
    end
    res_d.total_blocks = s2_q.blocks;
    if (oob_override_q != '0) begin
      res_d.oob_size_bytes = oob_override_q;
    end else if (s2_q.special_id) begin
      res_d.oob_size_bytes = SPECIAL_OOB;
    end else begin
      res_d.oob_size_bytes = s2_q.oob_calc;
    end
    res_d.wide_bus = s2_q.wide;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && adv3) res_q <= res_d;
  end

  // Output ports
  assign out_valid_o         = v3_q;
  assign chip_size_mb_o      = res_q.chip_size_mb;
  assign page_size_bytes_o   = res_q.page_size_bytes;
  assign block_size_kb_o     = res_q.block_size_kb;
  assign sectors_per_page_o  = res_q.sectors_per_page;
  assign bch_selected_o      = res_q.bch_selected;
  assign ecc_size_bytes_o    = res_q.ecc_size_bytes;
  assign ecc_correct_bits_o  = res_q.ecc_correct_bits;
  assign bad_mark_position_o = res_q.bad_mark_position;
  assign bad_mark_in_spare_o = res_q.bad_mark_in_spare;
  assign total_blocks_o      = res_q.total_blocks;
  assign oob_size_bytes_o    = res_q.oob_size_bytes;
  assign wide_bus_o          = res_q.wide_bus;

`ifndef SYNTHESIS
  // a full, stalled pipeline must refuse new requests
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !out_ready_i) |-> !in_ready_o)
    else $error("request taken while pipeline full and stalled");

  // the marker position is never left at zero
  a_mark_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bad_mark_position_o != '0))
    else $error("bad-block marker position is zero");

  // an unknown device gives the default block count
  a_unknown_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (chip_size_mb_o == '0)) |-> (total_blocks_o == UNKNOWN_BLOCKS))
    else $error("unknown device without default block count");

  // sectors per page is always a single power of two
  a_spp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(sectors_per_page_o))
    else $error("sectors per page not a power of two");
`endif

endmodule
